// ----- rtl/plus_stencil_light_smoothing_macros.svh -----
// assertion helpers shared by the smoothing filter modules
`ifndef PLUS_STENCIL_LIGHT_SMOOTHING_MACROS_SVH
`define PLUS_STENCIL_LIGHT_SMOOTHING_MACROS_SVH

// same-cycle implication, quiet while in reset
`define PLS_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, quiet while in reset
`define PLS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/pls_pkg.sv -----
package pls_pkg;

	localparam int SAMPLE_W = 16;
	localparam int DIM_W    = 7;
	localparam int SUM_W    = 19;
	localparam int CNT_W    = 3;

	// configuration register indexes
	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

	localparam logic [DIM_W-1:0] DIM_RESET = 7'd66;
	localparam int DIM_MIN = 3;

	// reciprocals for division by three and five, exact for sums below 2^19
	localparam int RECIP_W     = 20;
	localparam int RECIP_SHIFT = 21;
	localparam logic [RECIP_W-1:0] RECIP3 = 20'd699051;
	localparam logic [RECIP_W-1:0] RECIP5 = 20'd419431;

	typedef logic [SAMPLE_W-1:0] sample_t;

	// five neighborhood samples of one interior pixel
	typedef struct packed {
		sample_t centre;
		sample_t top;
		sample_t bottom;
		sample_t left;
		sample_t right;
		logic    last;
	} pls_ops_t;

endpackage

// ----- rtl/pls_line_ram.sv -----
module pls_line_ram
	import pls_pkg::*;
#(
	parameter int DEPTH = 66,
	parameter int AW    = 7
) (
	input  logic          clk,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  sample_t       wr_data,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output sample_t       rd_data
);

	sample_t mem_q [DEPTH];
	sample_t rd_q;

	// one write port, one registered read port, read returns the old word
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_q;

endmodule

// ----- rtl/pls_window.sv -----
`include "plus_stencil_light_smoothing_macros.svh"

module pls_window
	import pls_pkg::*;
#(
	parameter int MAX_WIDTH  = 64,
	parameter int MAX_HEIGHT = 64,
	localparam int DEPTH = MAX_WIDTH + 2,
	localparam int AW    = $clog2(DEPTH),
	localparam int CW    = $clog2(MAX_WIDTH + 3),
	localparam int RW    = $clog2(MAX_HEIGHT + 3)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          restart,
	input  logic [CW-1:0] w_eff,
	input  logic [RW-1:0] h_eff,
	input  logic          in_valid,
	output logic          in_ready,
	input  sample_t       light_in,
	output logic          ops_valid,
	input  logic          ops_ready,
	output pls_ops_t      ops
);

	logic [CW-1:0] col_q;
	logic [RW-1:0] row_q;
	logic          sel_q;
	sample_t       first0_q, first1_q;
	sample_t       cen_q, lft_q;

	logic    v1_s1, prod_s1, last_s1, first_s1, sel_s1;
	sample_t sample_s1, above0_s1;

	logic     v2_s2;
	pls_ops_t ops_s2;

	logic          ready1, ready2, adv1, acc;
	logic          last_col, produce, last_pix;
	logic [CW-1:0] nxt_col;
	logic [AW-1:0] col_addr, above_addr;
	sample_t       rd0, rd1, rd_above, rd_two;

	// stage handshake
	assign ready2   = !v2_s2 || ops_ready;
	assign adv1     = v1_s1 && ready2;
	assign ready1   = !v1_s1 || ready2;
	assign in_ready = ready1;
	assign acc      = in_valid && ready1;

	// position decode for the incoming word
	assign nxt_col  = col_q + CW'(1);
	assign last_col = (col_q == w_eff - CW'(1));
	assign produce  = (row_q >= RW'(2)) && (col_q != '0) && !last_col;
	assign last_pix = (row_q == h_eff - RW'(1)) && (col_q == w_eff - CW'(2));

	assign col_addr   = col_q[AW-1:0];
	assign above_addr = last_col ? '0 : nxt_col[AW-1:0];

	// bank sel_q holds the row above, the other the row two above
	pls_line_ram #(.DEPTH(DEPTH), .AW(AW)) u_bank0 (
		.clk     (clk),
		.wr_en   (acc && sel_q),
		.wr_addr (col_addr),
		.wr_data (light_in),
		.rd_en   (acc),
		.rd_addr (sel_q ? col_addr : above_addr),
		.rd_data (rd0)
	);

	pls_line_ram #(.DEPTH(DEPTH), .AW(AW)) u_bank1 (
		.clk     (clk),
		.wr_en   (acc && !sel_q),
		.wr_addr (col_addr),
		.wr_data (light_in),
		.rd_en   (acc),
		.rd_addr (sel_q ? above_addr : col_addr),
		.rd_data (rd1)
	);

	// raster position and bank swap
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
			sel_q <= 1'b0;
		end else if (restart) begin
			col_q <= '0;
			row_q <= '0;
		end else if (acc) begin
			if (last_col) begin
				col_q <= '0;
				row_q <= (row_q == h_eff - RW'(1)) ? '0 : row_q + RW'(1);
				sel_q <= !sel_q;
			end else begin
				col_q <= nxt_col;
			end
		end
	end

	// copy of column zero of each bank, feeds the left tap at column one
	always_ff @(posedge clk) begin
		if (acc && col_q == '0) begin
			if (sel_q) begin
				first0_q <= light_in;
			end else begin
				first1_q <= light_in;
			end
		end
	end

	// stage 1 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_s1 <= 1'b0;
		end else if (acc) begin
			v1_s1 <= 1'b1;
		end else if (adv1) begin
			v1_s1 <= 1'b0;
		end
	end

	// stage 1 payload, line store data lands alongside
	always_ff @(posedge clk) begin
		if (acc) begin
			prod_s1   <= produce;
			last_s1   <= last_pix;
			first_s1  <= (col_q == '0);
			sel_s1    <= sel_q;
			sample_s1 <= light_in;
			above0_s1 <= sel_q ? first1_q : first0_q;
		end
	end

	assign rd_above = sel_s1 ? rd1 : rd0;
	assign rd_two   = sel_s1 ? rd0 : rd1;

	// horizontal window over the row above
	always_ff @(posedge clk) begin
		if (adv1) begin
			cen_q <= rd_above;
			lft_q <= first_s1 ? above0_s1 : cen_q;
		end
	end

	// stage 2 control, only interior pixels go on
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v2_s2 <= 1'b0;
		end else if (adv1) begin
			v2_s2 <= prod_s1;
		end else if (ops_ready) begin
			v2_s2 <= 1'b0;
		end
	end

	// stage 2 operands
	always_ff @(posedge clk) begin
		if (adv1) begin
			ops_s2.centre <= cen_q;
			ops_s2.top    <= rd_two;
			ops_s2.bottom <= sample_s1;
			ops_s2.left   <= lft_q;
			ops_s2.right  <= rd_above;
			ops_s2.last   <= last_s1;
		end
	end

	assign ops_valid = v2_s2;
	assign ops       = ops_s2;

	// checks
	`PLS_ASSERT_NOW(a_col_in_row, 1'b1, col_q < w_eff, "column past row end")
	`PLS_ASSERT_NEXT(a_bank_swap, acc && last_col && !restart, sel_q != $past(sel_q),
		"banks not swapped at row end")
	`PLS_ASSERT_NEXT(a_frame_wrap, acc && last_col && row_q == h_eff - RW'(1), row_q == '0,
		"row did not wrap at frame end")

endmodule

// ----- rtl/pls_smooth.sv -----
`include "plus_stencil_light_smoothing_macros.svh"

module pls_smooth
	import pls_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     ops_valid,
	output logic     ops_ready,
	input  pls_ops_t ops,
	output logic     out_valid,
	input  logic     out_ready,
	output sample_t  light_out,
	output logic     frame_last
);

	localparam int PROD_W = SUM_W + RECIP_W;

	logic             v3_s3, v4_s4, v5_s5;
	logic [SUM_W-1:0] sum_s3, sum_s4;
	logic [CNT_W-1:0] cnt_s3, cnt_s4;
	sample_t          left_s3, right_s3, q_s5;
	logic             last_s3, last_s4, last_s5;

	logic              r3, r4, r5;
	logic [SUM_W-1:0]  sum_a, sum_b, t_x, b_x, l_x, r_x;
	logic [CNT_W-1:0]  cnt_a, cnt_b;
	logic [RECIP_W-1:0] recip;
	logic [PROD_W-1:0] prod;
	sample_t           quot;

	// stage handshake
	assign r5 = !v5_s5 || out_ready;
	assign r4 = !v4_s4 || r5;
	assign r3 = !v3_s3 || r4;
	assign ops_ready = r3;

	// top then bottom, each added only when above the running sum
	always_comb begin
		t_x   = SUM_W'(ops.top);
		b_x   = SUM_W'(ops.bottom);
		sum_a = SUM_W'(ops.centre);
		cnt_a = CNT_W'(1);
		if (t_x > sum_a) begin
			sum_a = sum_a + t_x;
			cnt_a = cnt_a + CNT_W'(1);
		end
		if (b_x > sum_a) begin
			sum_a = sum_a + b_x;
			cnt_a = cnt_a + CNT_W'(1);
		end
	end

	// left then right
	always_comb begin
		l_x   = SUM_W'(left_s3);
		r_x   = SUM_W'(right_s3);
		sum_b = sum_s3;
		cnt_b = cnt_s3;
		if (l_x > sum_b) begin
			sum_b = sum_b + l_x;
			cnt_b = cnt_b + CNT_W'(1);
		end
		if (r_x > sum_b) begin
			sum_b = sum_b + r_x;
			cnt_b = cnt_b + CNT_W'(1);
		end
	end

	// divide by count: shifts for one, two, four, reciprocal multiply otherwise
	always_comb begin
		case (cnt_s4)
			3'd3:    recip = RECIP3;
			3'd5:    recip = RECIP5;
			default: recip = '0;
		endcase
		prod = PROD_W'(sum_s4) * PROD_W'(recip);
		case (cnt_s4)
			3'd2:    quot = sum_s4[SAMPLE_W:1];
			3'd3:    quot = prod[RECIP_SHIFT +: SAMPLE_W];
			3'd4:    quot = sum_s4[SAMPLE_W+1:2];
			3'd5:    quot = prod[RECIP_SHIFT +: SAMPLE_W];
			default: quot = sum_s4[SAMPLE_W-1:0];
		endcase
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v3_s3 <= 1'b0;
			v4_s4 <= 1'b0;
			v5_s5 <= 1'b0;
		end else begin
			if (r3) v3_s3 <= ops_valid;
			if (r4) v4_s4 <= v3_s3;
			if (r5) v5_s5 <= v4_s4;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (r3 && ops_valid) begin
			sum_s3   <= sum_a;
			cnt_s3   <= cnt_a;
			left_s3  <= ops.left;
			right_s3 <= ops.right;
			last_s3  <= ops.last;
		end
		if (r4 && v3_s3) begin
			sum_s4  <= sum_b;
			cnt_s4  <= cnt_b;
			last_s4 <= last_s3;
		end
		if (r5 && v4_s4) begin
			q_s5    <= quot;
			last_s5 <= last_s4;
		end
	end

	assign out_valid  = v5_s5;
	assign light_out  = q_s5;
	assign frame_last = last_s5;

	// checks
	`PLS_ASSERT_NOW(a_cnt_mid, v3_s3, cnt_s3 != '0 && cnt_s3 <= CNT_W'(3),
		"count after two taps out of range")
	`PLS_ASSERT_NOW(a_cnt_end, v4_s4, cnt_s4 != '0 && cnt_s4 <= CNT_W'(5),
		"final count out of range")
	`PLS_ASSERT_NEXT(a_no_drop, v4_s4 && r5, v5_s5, "word lost before output stage")

endmodule

// ----- rtl/plus_stencil_light_smoothing.sv -----
// Four-neighbor light smoothing over a padded raster stream.
// Input channel in_valid/in_ready/light_in takes one unsigned Q8.8 word per
// cycle in raster order, halo rows and columns included. Output channel
// out_valid/out_ready carries light_out for each interior pixel and
// frame_last on the last interior pixel of the frame; halo words and the
// first two rows give no output.
// A word is accepted every cycle while the output side keeps up. A
// result is registered in turn after the line store read at the edge
// that took the word below its pixel: neighborhood, then the compare-add
// chain over top and bottom, then over left and right, then the divide.
// When the receiver stalls, the five stage registers fill up in turn and
// in_ready drops only once the word in the first stage cannot move.
// The configuration port writes frame_width (index 0) or frame_height
// (index 1); each write restarts the frame at its first row and column.
// Write it only while no word is in flight.
// Reset clears the raster position and all valid bits and sets both
// dimensions to 66; line store contents are not cleared.
module plus_stencil_light_smoothing
	import pls_pkg::*;
#(
	parameter int MAX_WIDTH  = 64,
	parameter int MAX_HEIGHT = 64
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_write,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [DIM_W-1:0]     cfg_data,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [15:0]          light_in,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [15:0]          light_out,
	output logic                 frame_last
);

	localparam int WMAX = MAX_WIDTH + 2;
	localparam int HMAX = MAX_HEIGHT + 2;
	localparam int CW   = $clog2(MAX_WIDTH + 3);
	localparam int RW   = $clog2(MAX_HEIGHT + 3);

	logic [DIM_W-1:0] width_q, height_q;
	logic [CW-1:0]    w_eff;
	logic [RW-1:0]    h_eff;
	logic             ops_valid, ops_ready;
	pls_ops_t         ops;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= DIM_RESET;
			height_q <= DIM_RESET;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_FRAME_WIDTH:  width_q  <= cfg_data;
				REG_FRAME_HEIGHT: height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// clamp dimensions to the supported range
	always_comb begin
		if (int'(width_q) < DIM_MIN) begin
			w_eff = CW'(DIM_MIN);
		end else if (int'(width_q) > WMAX) begin
			w_eff = CW'(WMAX);
		end else begin
			w_eff = CW'(width_q);
		end
		if (int'(height_q) < DIM_MIN) begin
			h_eff = RW'(DIM_MIN);
		end else if (int'(height_q) > HMAX) begin
			h_eff = RW'(HMAX);
		end else begin
			h_eff = RW'(height_q);
		end
	end

	// line stores and neighborhood
	pls_window #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_window (
		.clk       (clk),
		.arst_n    (arst_n),
		.restart   (cfg_write),
		.w_eff     (w_eff),
		.h_eff     (h_eff),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.light_in  (light_in),
		.ops_valid (ops_valid),
		.ops_ready (ops_ready),
		.ops       (ops)
	);

	// compare-add chain and divide
	pls_smooth u_smooth (
		.clk        (clk),
		.arst_n     (arst_n),
		.ops_valid  (ops_valid),
		.ops_ready  (ops_ready),
		.ops        (ops),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.light_out  (light_out),
		.frame_last (frame_last)
	);

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 100ps

module testbench;
	import pls_pkg::*;

	localparam int MAX_W = 64;
	localparam int MAX_H = 64;
	localparam int LINE_DEPTH = MAX_W + 2;
	localparam int RANDOM_WORDS = 1200;
	localparam int TAIL_CYCLES = 16;
	localparam int CYCLE_LIMIT = 400000;

	typedef struct packed {
		sample_t light;
		logic    last;
	} smoothed_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_write = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = REG_FRAME_WIDTH;
	logic [DIM_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [15:0] light_in = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [15:0] light_out;
	logic frame_last;

	// predictor state: two line stores, raster position, dimensions
	sample_t light_lines [2][LINE_DEPTH];
	bit above_sel = 1'b0;
	int unsigned raster_col = 0;
	int unsigned raster_row = 0;
	logic [DIM_W-1:0] width_reg = DIM_RESET;
	logic [DIM_W-1:0] height_reg = DIM_RESET;

	sample_t pending_light[$];
	smoothed_t smoothed_q[$];
	int unsigned issued = 0;
	int unsigned taken = 0;
	int unsigned random_words = 0;
	int fails = 0;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int cycles = 0;

	plus_stencil_light_smoothing #(
		.MAX_WIDTH (MAX_W),
		.MAX_HEIGHT(MAX_H)
	) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.light_in  (light_in),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.light_out (light_out),
		.frame_last(frame_last)
	);

	always #2 clk = ~clk;

	function automatic int unsigned clamp_dim(input int unsigned v, input int unsigned hi);
		if (v < DIM_MIN)
			return DIM_MIN;
		if (v > hi)
			return hi;
		return v;
	endfunction

	// centre plus each neighbor that beats the running sum, then the mean
	function automatic sample_t stencil_mean(input sample_t ctr, input sample_t t,
			input sample_t b, input sample_t l, input sample_t rt);
		sample_t nb [4];
		int unsigned acc;
		int unsigned n;
		nb = '{t, b, l, rt};
		acc = ctr;
		n = 1;
		foreach (nb[i]) begin
			if (nb[i] > acc) begin
				acc += nb[i];
				n++;
			end
		end
		return sample_t'(acc / n);
	endfunction

	// one accepted word: maybe a smoothed pixel, then line store update
	function automatic void advance_raster(input sample_t px);
		int unsigned w;
		int unsigned h;
		int unsigned c;
		int unsigned r;
		smoothed_t res;
		w = clamp_dim(width_reg, MAX_W + 2);
		h = clamp_dim(height_reg, MAX_H + 2);
		c = (raster_col >= w) ? w - 1 : raster_col;
		r = (raster_row >= h) ? h - 1 : raster_row;
		if (r >= 2 && c >= 1 && c + 1 < w) begin
			res.light = stencil_mean(light_lines[above_sel][c], light_lines[!above_sel][c],
				px, light_lines[above_sel][c-1], light_lines[above_sel][c+1]);
			res.last = (r == h - 1 && c == w - 2);
			smoothed_q.push_back(res);
		end
		light_lines[!above_sel][c] = px;
		if (c + 1 >= w) begin
			above_sel = !above_sel;
			raster_col = 0;
			raster_row = (r + 1 >= h) ? 0 : r + 1;
		end else begin
			raster_col = c + 1;
			raster_row = r;
		end
	endfunction

	// light values spread over all magnitudes so neighbors often beat the sum
	function automatic sample_t rand_light();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			default: return sample_t'($urandom_range(0, 65535) >> $urandom_range(0, 16));
		endcase
	endfunction

	task automatic queue_word(input sample_t v);
		issued++;
		pending_light.push_back(v);
	endtask

	task automatic queue_random(input int unsigned n);
		repeat (n)
			queue_word(rand_light());
		random_words += n;
	endtask

	// 3x3 padded frame, corners filled with halo value
	task automatic queue_tiny_frame(input sample_t halo, input sample_t ctr, input sample_t t,
			input sample_t b, input sample_t l, input sample_t rt);
		queue_word(halo); queue_word(t);   queue_word(halo);
		queue_word(l);    queue_word(ctr); queue_word(rt);
		queue_word(halo); queue_word(b);   queue_word(halo);
	endtask

	// register write, only called while nothing is in flight
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DIM_W-1:0] val);
		@(posedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_write <= 1'b0;
		if (idx == REG_FRAME_WIDTH)
			width_reg = val;
		else
			height_reg = val;
		raster_col = 0;
		raster_row = 0;
	endtask

	// wait for every word taken and every result seen, then let the pipe empty
	task automatic settle();
		while (taken != issued || smoothed_q.size() != 0)
			@(negedge clk);
		repeat (TAIL_CYCLES) @(negedge clk);
	endtask

	// driver: present queued words, idle at random between them
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			light_in <= '0;
		end else begin
			if (in_valid && in_ready) begin
				advance_raster(light_in);
				taken++;
			end
			if (!in_valid || in_ready) begin
				if (pending_light.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
					in_valid <= 1'b1;
					light_in <= pending_light.pop_front();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// monitor: compare each result word with the oldest prediction
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (smoothed_q.size() == 0) begin
					$error("unexpected result word: light_out %0d frame_last %0b",
						light_out, frame_last);
					fails++;
				end else begin
					smoothed_t want;
					want = smoothed_q.pop_front();
					if (light_out !== want.light) begin
						$error("light_out: expected %0d, got %0d", want.light, light_out);
						fails++;
					end
					if (frame_last !== want.last) begin
						$error("frame_last: expected %0b, got %0b", want.last, frame_last);
						fails++;
					end
				end
			end
			out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("plus_stencil_light_smoothing: mismatch");
			$finish;
		end
	end

	initial begin
		int unsigned pick;
		int unsigned wr;
		int unsigned hr;
		int unsigned w;
		int unsigned h;
		int unsigned span;
		int unsigned n;

		send_idle_pct = 20;
		recv_idle_pct = 64;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// reset dimensions: two full rows, then three to 66 words of the third
		queue_random(2 * 66 + $urandom_range(3, 66));
		settle();

		// tiny frames: dimensions below range clamp to three
		write_reg(REG_FRAME_WIDTH, 7'd2);
		write_reg(REG_FRAME_HEIGHT, 7'd1);
		// every neighbor beats the sum
		queue_tiny_frame(16'h0000, 16'd0, 16'd1, 16'd2, 16'd4, 16'd8);
		// sum wider than a sample
		queue_tiny_frame(16'hFFFF, 16'd1, 16'd2, 16'd4, 16'd8, 16'hFFFF);
		// equal neighbor is not added, zero halo passes the centre through
		queue_tiny_frame(16'h0000, 16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000);
		settle();

		// random frames under changing dimensions
		while (random_words < RANDOM_WORDS) begin
			if (random_words < RANDOM_WORDS / 3) begin
				send_idle_pct = 20;
				recv_idle_pct = 64;
			end else if (random_words < 2 * RANDOM_WORDS / 3) begin
				send_idle_pct = 64;
				recv_idle_pct = 20;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			pick = $urandom_range(0, 19);
			if (pick < 5) begin
				wr = 66;
				hr = $urandom_range(3, 6);
			end else if (pick < 8) begin
				wr = $urandom_range(3, 5);
				hr = 66;
			end else if (pick < 11) begin
				wr = $urandom_range(0, 127);
				hr = $urandom_range(0, 127);
			end else begin
				wr = $urandom_range(3, 12);
				hr = $urandom_range(3, 12);
			end
			if ($urandom_range(0, 1)) begin
				write_reg(REG_FRAME_WIDTH, DIM_W'(wr));
				write_reg(REG_FRAME_HEIGHT, DIM_W'(hr));
			end else begin
				write_reg(REG_FRAME_HEIGHT, DIM_W'(hr));
				write_reg(REG_FRAME_WIDTH, DIM_W'(wr));
			end
			w = clamp_dim(wr, MAX_W + 2);
			h = clamp_dim(hr, MAX_H + 2);
			span = w * h;
			n = span * $urandom_range(1, 2);
			// sometimes stop mid frame so the next write restarts it
			if ($urandom_range(0, 2) == 0)
				n += $urandom_range(1, span - 1);
			if (n > 700)
				n = $urandom_range(2 * w + 1, 5 * w);
			queue_random(n);
			settle();
		end

		if (smoothed_q.size() != 0) begin
			$error("%0d result words never arrived", smoothed_q.size());
			fails++;
		end
		if (fails == 0)
			$display("plus_stencil_light_smoothing: match");
		else
			$display("plus_stencil_light_smoothing: mismatch");
		$finish;
	end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/pls_pkg.sv
rtl/pls_line_ram.sv
rtl/pls_window.sv
rtl/pls_smooth.sv
rtl/plus_stencil_light_smoothing.sv
tb/testbench.sv
